// ===== rtl/crfq_pkg.sv =====
// crfq_pkg: shared types and constants of the CAN receive filter queue
// no dependencies; imported by can_rx_filter_queue_top
`timescale 1ns / 1ps
`default_nettype none

package crfq_pkg;

   // queue geometry (depth must be a power of two, slots wrap naturally)
   localparam int QUEUE_DEPTH  = 32;
   localparam int QIDX_W       = $clog2(QUEUE_DEPTH);
   localparam int FILL_W       = $clog2(QUEUE_DEPTH + 1);

   // acceptance bitmap geometry
   localparam int BITMAP_DEPTH = 256;
   localparam int BITMAP_AW    = $clog2(BITMAP_DEPTH);

   // frame fields
   localparam int ID_W         = 29;
   localparam int LEN_W        = 4;
   localparam int PAY_W        = 64;
   localparam logic [LEN_W-1:0] MAX_DATA_LEN = 4'd8;

   // request tdata layout, lowest bit first
   localparam int REQ_WORD_LO  = 0;
   localparam int REQ_LEN_LO   = 32;
   localparam int REQ_PLO_LO   = 36;
   localparam int REQ_PHI_LO   = 68;
   localparam int REQ_BIDX_LO  = 100;
   localparam int REQ_BBYTE_LO = 108;
   localparam int REQ_ROFS_LO  = 116;
   localparam int REQ_ROFS_W   = 5;
   localparam int REQ_TDATA_W  = 128;

   // response tdata layout, lowest bit first
   localparam int RSP_TDATA_W  = 112;

   // item kinds carried in req_tuser
   typedef enum logic [1:0] {
      MODE_FRAME   = 2'd0,
      MODE_BMAP_WR = 2'd1,
      MODE_READ    = 2'd2,
      MODE_RELEASE = 2'd3
   } mode_type;

   // result status codes
   typedef enum logic [1:0] {
      ST_STORED   = 2'd0,
      ST_FULL     = 2'd1,
      ST_FILTERED = 2'd2,
      ST_OTHER    = 2'd3
   } status_type;

   // one queued frame header
   typedef struct packed {
      logic             ext;
      logic [ID_W-1:0]  ident;
      logic [LEN_W-1:0] len;
   } header_type;

endpackage

`default_nettype wire

// ===== rtl/crfq_ram.sv =====
// crfq_ram: generic single write port, single read port RAM with registered read
// no dependencies; used for the acceptance bitmap
`timescale 1ns / 1ps
`default_nettype none

module crfq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds while rd_en is low
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/can_rx_filter_queue_top.sv =====
// can_rx_filter_queue_top: CAN receive acceptance bitmap and frame ring queue
// depends on crfq_pkg and crfq_ram
//
//   channel | dir | handshake              | carries
//   req     | in  | req_tvalid/req_tready  | tuser: mode, tdata: frame/bitmap/read fields
//   rsp     | out | rsp_tvalid/rsp_tready  | tdata: status, count, frame read back
//   csr     | in  | csr_valid/csr_ready    | filter_enable
//
// One item per clock sustained while the result is not stalled; each item is registered
// in the input stage (bitmap RAM read) and is then resolved into the result register,
// which raises rsp_tvalid. Bitmap writes land at acceptance.
// Synchronous reset clears the queue pointers, the filter enable and the bitmap
// valid bits, so the whole bitmap reads as reject-all with no clearing pass.
// A stalled result holds the input stage, which then holds req_tready low.
`timescale 1ns / 1ps
`default_nettype none

module can_rx_filter_queue_top
   import crfq_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output logic                        req_tready,
   // mode[1:0]
   input  wire logic [1:0]             req_tuser,
   // id_word[31:0], raw_length[35:32], payload_low[67:36], payload_high[99:68],
   // bitmap_index[107:100], bitmap_byte[115:108], read_offset[120:116], zero pad
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                        rsp_tvalid,
   input  wire logic                   rsp_tready,
   // status[1:0], queued_count[7:2], out_extended[8], out_identifier[37:9],
   // out_length[41:38], out_payload_low[73:42], out_payload_high[105:74], zero pad
   output logic      [RSP_TDATA_W-1:0] rsp_tdata,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic                   csr_data
);

   // handshakes
   logic req_accept;
   logic s1_advance;

   // config
   logic filter_en_ff;

   // input stage
   logic                   s1_valid_ff;
   mode_type               s1_mode_ff;
   logic [REQ_TDATA_W-1:0] s1_data_ff;
   logic                   s1_bmap_vld_ff;
   logic [7:0]             bmap_rd_data;

   // bitmap valid bits and RAM ports
   logic [BITMAP_DEPTH-1:0] bmap_vld_ff;
   logic                    bmap_we;
   logic                    bmap_re;
   logic [BITMAP_AW-1:0]    bmap_wr_addr;
   logic [BITMAP_AW-1:0]    bmap_rd_addr;

   // queue state
   logic [QIDX_W-1:0] head_ff;
   logic [QIDX_W-1:0] head_in;
   logic [FILL_W-1:0] fill_ff;
   logic [FILL_W-1:0] fill_in;
   header_type        hdr_store_ff [QUEUE_DEPTH];
   logic [PAY_W-1:0]  pay_store_ff [QUEUE_DEPTH];

   // resolve stage
   logic [31:0]       s1_word;
   logic [LEN_W-1:0]  s1_raw_len;
   logic              frame_ext;
   logic [ID_W-1:0]   frame_ident;
   logic [LEN_W-1:0]  frame_len;
   logic              bmap_hit;
   logic [QIDX_W-1:0] wr_slot;
   logic [QIDX_W-1:0] rd_slot;
   logic              store_we;
   status_type        status;
   header_type        hdr_rd;
   logic [PAY_W-1:0]  pay_rd;

   // result register
   logic                   rsp_valid_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   // handshake logic
   assign s1_advance = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_advance;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   // filter enable register
   always_ff @(posedge clock) begin
      if (reset) begin
         filter_en_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         filter_en_ff <= csr_data;
      end
   end

   // bitmap access at acceptance: writes for bitmap transactions,
   // lookup of the standard id byte for frame transactions
   assign bmap_we      = req_accept && (mode_type'(req_tuser) == MODE_BMAP_WR);
   assign bmap_re      = req_accept && (mode_type'(req_tuser) == MODE_FRAME);
   assign bmap_wr_addr = req_tdata[REQ_BIDX_LO +: BITMAP_AW];
   assign bmap_rd_addr = req_tdata[REQ_WORD_LO + 24 +: BITMAP_AW];

   crfq_ram #(
      .WIDTH (8),
      .DEPTH (BITMAP_DEPTH)
   ) u_bitmap_ram (
      .clock   (clock),
      .wr_en   (bmap_we),
      .wr_addr (bmap_wr_addr),
      .wr_data (req_tdata[REQ_BBYTE_LO +: 8]),
      .rd_en   (bmap_re),
      .rd_addr (bmap_rd_addr),
      .rd_data (bmap_rd_data)
   );

   // bitmap valid bits, an entry never written reads as reject
   always_ff @(posedge clock) begin
      if (reset) begin
         bmap_vld_ff <= '0;
      end else if (bmap_we) begin
         bmap_vld_ff[bmap_wr_addr] <= 1'b1;
      end
   end

   // input stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_advance) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // input stage payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_mode_ff     <= mode_type'(req_tuser);
         s1_data_ff     <= req_tdata;
         s1_bmap_vld_ff <= bmap_vld_ff[bmap_rd_addr];
      end
   end

   // frame decode
   assign s1_word     = s1_data_ff[REQ_WORD_LO +: 32];
   assign s1_raw_len  = s1_data_ff[REQ_LEN_LO +: LEN_W];
   assign frame_ext   = s1_word[2];
   assign frame_ident = frame_ext ? s1_word[31:3] : {{(ID_W - 11){1'b0}}, s1_word[31:21]};
   assign frame_len   = (s1_raw_len > MAX_DATA_LEN) ? MAX_DATA_LEN : s1_raw_len;
   assign bmap_hit    = s1_bmap_vld_ff && bmap_rd_data[s1_word[23:21]];
   assign wr_slot     = head_ff + fill_ff[QIDX_W-1:0];
   assign rd_slot     = head_ff + QIDX_W'(s1_data_ff[REQ_ROFS_LO +: REQ_ROFS_W]);

   // resolve one transaction against the queue state
   always_comb begin
      head_in  = head_ff;
      fill_in  = fill_ff;
      store_we = 1'b0;
      status   = ST_OTHER;
      hdr_rd   = '0;
      pay_rd   = '0;
      unique case (s1_mode_ff)
         MODE_FRAME: begin
            // full check comes ahead of the filter
            if (fill_ff >= FILL_W'(QUEUE_DEPTH)) begin
               status = ST_FULL;
            end else if (filter_en_ff && !frame_ext && !bmap_hit) begin
               status = ST_FILTERED;
            end else begin
               status   = ST_STORED;
               store_we = 1'b1;
               fill_in  = fill_ff + FILL_W'(1);
            end
         end
         MODE_BMAP_WR: begin
            status = ST_OTHER;
         end
         MODE_READ: begin
            hdr_rd = hdr_store_ff[rd_slot];
            pay_rd = pay_store_ff[rd_slot];
         end
         MODE_RELEASE: begin
            head_in = head_ff + fill_ff[QIDX_W-1:0];
            fill_in = '0;
         end
         default: begin
            status = ST_OTHER;
         end
      endcase
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         fill_ff <= '0;
      end else if (s1_advance) begin
         head_ff <= head_in;
         fill_ff <= fill_in;
      end
   end

   // frame stores
   always_ff @(posedge clock) begin
      if (s1_advance && store_we) begin
         hdr_store_ff[wr_slot] <= '{ext: frame_ext, ident: frame_ident, len: frame_len};
         pay_store_ff[wr_slot] <= {s1_data_ff[REQ_PHI_LO +: 32], s1_data_ff[REQ_PLO_LO +: 32]};
      end
   end

   // result packing
   assign rsp_data_in = {
      6'd0,
      pay_rd[63:32],
      pay_rd[31:0],
      hdr_rd.len,
      hdr_rd.ident,
      hdr_rd.ext,
      fill_in,
      status
   };

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // checks
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(QUEUE_DEPTH))
      else $error("queue fill beyond depth");

   a_store_counts: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && store_we) |=> (fill_ff == $past(fill_ff) + FILL_W'(1)))
      else $error("stored frame not counted");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_data_ff[1:0] == ST_FULL))
         |-> (rsp_data_ff[7:2] == FILL_W'(QUEUE_DEPTH)))
      else $error("queue full reported below depth");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff && !rsp_tready))
      else $error("input stalled without a blocked result");

   a_frame_fields: assert property (@(posedge clock) disable iff (reset)
      (s1_advance && (s1_mode_ff != MODE_READ)) |=> (rsp_data_ff[105:8] == '0))
      else $error("frame fields set outside a read");

endmodule

`default_nettype wire
